/* hw/rtl/mddg_pkg.sv */
// Shared constants, outcome codes and table interface types for the
// message dedup delivery gate. No dependencies.
package mddg_pkg;

  // Seen table geometry
  localparam int SEEN_DEPTH = 16;
  localparam int IDX_W      = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int CNT_W      = $clog2(SEEN_DEPTH + 1);

  // Field widths
  localparam int IDENT_W   = 32;
  localparam int KEY_W     = 2 * IDENT_W;
  localparam int OUTCOME_W = 3;
  localparam int TOTAL_W   = 32;

  // Outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_DELIVERED      = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_DUPLICATE      = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_STOPPED        = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_RF_UNAVAILABLE = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_STORAGE        = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_FAILED         = 3'd5;

  // Commands from the sequencer to the seen table
  typedef struct packed {
    logic             search;
    logic             insert;
    logic [KEY_W-1:0] key;
  } tbl_cmd_t;

  // Status back from the seen table
  typedef struct packed {
    logic done;
    logic hit;
  } tbl_sts_t;

endpackage

/* hw/rtl/mddg_seen_table.sv */
// Seen table: FIFO-replaced store of delivered (source, message) pairs with a
// serial search that reuses one 64-bit comparator per entry. Uses mddg_pkg.
module mddg_seen_table
  import mddg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_cmd_t cmd_i,
  output tbl_sts_t sts_o
);

  logic [KEY_W-1:0] mem [SEEN_DEPTH];

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] rd_data_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] next_r, next_nxt;
  logic [CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic             scan_on_r, scan_on_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             rd_last_r, rd_last_nxt;
  logic             done_r, done_nxt;
  logic             hit_r, hit_nxt;

  logic             last_issue;
  logic             match;
  logic             finish;

  // Shared compare unit on the registered read data
  assign match      = rd_vld_r && (rd_data_r == key_r);
  assign finish     = rd_vld_r && (match || rd_last_r);
  assign last_issue = ((scan_cnt_r + CNT_W'(1)) == fill_r);

  // Scan sequencer and FIFO pointers
  always_comb begin
    scan_on_nxt  = scan_on_r;
    scan_cnt_nxt = scan_cnt_r;
    rd_vld_nxt   = 1'b0;
    rd_last_nxt  = rd_last_r;
    done_nxt     = 1'b0;
    hit_nxt      = hit_r;
    fill_nxt     = fill_r;
    next_nxt     = next_r;

    if (scan_on_r) begin
      rd_vld_nxt   = 1'b1;
      rd_last_nxt  = last_issue;
      scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
      if (last_issue) begin
        scan_on_nxt = 1'b0;
      end
    end

    // stop on a hit or after the last entry; drop the read still in flight
    if (finish) begin
      done_nxt    = 1'b1;
      hit_nxt     = match;
      scan_on_nxt = 1'b0;
      rd_vld_nxt  = 1'b0;
    end

    if (cmd_i.search) begin
      hit_nxt      = 1'b0;
      scan_cnt_nxt = '0;
      if (fill_r == '0) begin
        done_nxt = 1'b1;
      end else begin
        scan_on_nxt = 1'b1;
      end
    end

    // next_r equals fill_r until the table is full, then wraps oldest-first
    if (cmd_i.insert) begin
      next_nxt = (next_r == IDX_W'(SEEN_DEPTH - 1)) ? '0 : next_r + IDX_W'(1);
      if (fill_r != CNT_W'(SEEN_DEPTH)) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      next_r    <= '0;
      scan_on_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      done_r    <= 1'b0;
      hit_r     <= 1'b0;
      rd_last_r <= 1'b0;
      scan_cnt_r <= '0;
    end else begin
      fill_r     <= fill_nxt;
      next_r     <= next_nxt;
      scan_on_r  <= scan_on_nxt;
      rd_vld_r   <= rd_vld_nxt;
      done_r     <= done_nxt;
      hit_r      <= hit_nxt;
      rd_last_r  <= rd_last_nxt;
      scan_cnt_r <= scan_cnt_nxt;
    end
  end

  // Key capture
  always_ff @(posedge clk) begin
    if (cmd_i.search) begin
      key_r <= cmd_i.key;
    end
  end

  // Table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd_i.insert) begin
      mem[next_r] <= cmd_i.key;
    end
    if (scan_on_r) begin
      rd_data_r <= mem[scan_cnt_r[IDX_W-1:0]];
    end
  end

  assign sts_o.done = done_r;
  assign sts_o.hit  = hit_r;

endmodule

/* hw/rtl/message_dedup_delivery_gate_core.sv */
// Top level of the message dedup delivery gate: handshakes, outcome decision,
// counters and result register. Uses mddg_pkg and mddg_seen_table.
//
// Usage:
//   Input channel (in_*): one delivery attempt per transfer, a source and
//   message ident plus the radio and storage results. in_ready is high only
//   while the sequencer is idle.
//   Result channel (out_*): one transfer per attempt with the outcome code and
//   both wrapping totals as they stand after the attempt.
//   cfg_wr_en/cfg_wr_data set gateway_active; write only while idle.
// Timing:
//   A stopped attempt skips the table search and goes straight to its result.
//   Otherwise the seen table (16 entries) is searched one entry per cycle
//   with a single 64-bit comparator on registered memory data, ending early
//   when a duplicate is found. One attempt is in work at a time.
// Reset: table empty, counters zero, gateway inactive, no result pending.
// Stall: a finished result sits in the output register; the next attempt is
//   accepted meanwhile and waits in its result state until the register frees.
module message_dedup_delivery_gate_core
  import mddg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IDENT_W-1:0]   in_source_ident,
  input  logic [IDENT_W-1:0]   in_message_ident,
  input  logic                 in_to_radio,
  input  logic                 in_radio_ok,
  input  logic                 in_radio_unavailable,
  input  logic                 in_store_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUTCOME_W-1:0] out_outcome,
  output logic [TOTAL_W-1:0]   out_delivered_total,
  output logic [TOTAL_W-1:0]   out_duplicate_total
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  logic                 active_r;
  logic [IDENT_W-1:0]   src_r;
  logic [IDENT_W-1:0]   msg_r;
  logic                 to_radio_r;
  logic                 radio_ok_r;
  logic                 radio_unav_r;
  logic                 store_ok_r;
  logic [OUTCOME_W-1:0] outcome_r, outcome_nxt;
  logic [TOTAL_W-1:0]   del_cnt_r, del_cnt_nxt;
  logic [TOTAL_W-1:0]   dup_cnt_r, dup_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUTCOME_W-1:0] out_outcome_r;
  logic [TOTAL_W-1:0]   out_del_r;
  logic [TOTAL_W-1:0]   out_dup_r;

  logic     in_xfer;
  logic     out_free;
  tbl_cmd_t tbl_cmd;
  tbl_sts_t tbl_sts;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Table commands: search on transfer when active, insert on delivery
  always_comb begin
    tbl_cmd.search = in_xfer && active_r;
    tbl_cmd.insert = 1'b0;
    tbl_cmd.key    = (state_r == S_IDLE) ? {in_source_ident, in_message_ident}
                                         : {src_r, msg_r};
    if (state_r == S_SEARCH && tbl_sts.done && !tbl_sts.hit &&
        !(to_radio_r && !radio_ok_r) && store_ok_r) begin
      tbl_cmd.insert = 1'b1;
    end
  end

  mddg_seen_table u_seen_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (tbl_cmd),
    .sts_o (tbl_sts)
  );

  // Sequencer and outcome decision
  always_comb begin
    state_nxt     = state_r;
    outcome_nxt   = outcome_r;
    del_cnt_nxt   = del_cnt_r;
    dup_cnt_nxt   = dup_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (active_r) begin
            state_nxt = S_SEARCH;
          end else begin
            outcome_nxt = OUT_STOPPED;
            state_nxt   = S_RESULT;
          end
        end
      end
      S_SEARCH: begin
        if (tbl_sts.done) begin
          state_nxt = S_RESULT;
          if (tbl_sts.hit) begin
            outcome_nxt = OUT_DUPLICATE;
            dup_cnt_nxt = dup_cnt_r + TOTAL_W'(1);
          end else if (to_radio_r && !radio_ok_r) begin
            outcome_nxt = radio_unav_r ? OUT_RF_UNAVAILABLE : OUT_FAILED;
          end else if (!store_ok_r) begin
            outcome_nxt = OUT_STORAGE;
          end else begin
            outcome_nxt = OUT_DELIVERED;
            del_cnt_nxt = del_cnt_r + TOTAL_W'(1);
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, counters and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      del_cnt_r   <= '0;
      dup_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      del_cnt_r   <= del_cnt_nxt;
      dup_cnt_r   <= dup_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    outcome_r <= outcome_nxt;
    if (in_xfer) begin
      src_r        <= in_source_ident;
      msg_r        <= in_message_ident;
      to_radio_r   <= in_to_radio;
      radio_ok_r   <= in_radio_ok;
      radio_unav_r <= in_radio_unavailable;
      store_ok_r   <= in_store_ok;
    end
    if (state_r == S_RESULT && out_free) begin
      out_outcome_r <= outcome_r;
      out_del_r     <= del_cnt_r;
      out_dup_r     <= dup_cnt_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_outcome         = out_outcome_r;
  assign out_delivered_total = out_del_r;
  assign out_duplicate_total = out_dup_r;

  // Table only reports back for a search we issued
  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_sts.done |-> state_r == S_SEARCH)
    else $error("seen table done outside search");

  // An accepted attempt blocks further input
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input accepted while busy");

  // Insert and search never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_cmd.insert |-> !tbl_cmd.search && state_r == S_SEARCH)
    else $error("table insert overlaps search");

  // A new result carries a legal outcome code
  a_outcome_legal: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_outcome_r <= OUT_FAILED)
    else $error("illegal outcome code");

endmodule
